// ----- design/terminal_key_decoder_cursor_assert.svh -----
// Assertion macros shared by the decoder RTL.
`ifndef TERMINAL_KEY_DECODER_CURSOR_ASSERT_SVH
`define TERMINAL_KEY_DECODER_CURSOR_ASSERT_SVH

// Same-cycle implication.
`define TKD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TKD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tkd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tkd_pkg;

  typedef logic [8:0] tkd_key_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       timed_out;
  } tkd_in_t;

  typedef struct packed {
    logic [8:0] key_code;
    logic [7:0] cursor_x;
    logic [7:0] cursor_y;
    logic       quit;
  } tkd_out_t;

  // front -> queue
  typedef struct packed {
    logic     push;
    tkd_key_t key;
  } tkd_push_t;

  // queue -> front/back
  typedef struct packed {
    logic full;
    logic empty;
  } tkd_qstat_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_ESC   = 4'b0010,
    PH_SEQ1  = 4'b0100,
    PH_DIGIT = 4'b1000
  } tkd_phase_t;

  localparam logic [0:0] REG_ROWS = 1'b0;
  localparam logic [0:0] REG_COLS = 1'b1;

  localparam logic [8:0] ROWS_RST = 9'd24;
  localparam logic [8:0] COLS_RST = 9'd80;

  localparam tkd_key_t K_ESC   = 9'd27;
  localparam tkd_key_t K_CTRLX = 9'd24;
  localparam tkd_key_t K_LEFT  = 9'd256;
  localparam tkd_key_t K_RIGHT = 9'd257;
  localparam tkd_key_t K_UP    = 9'd258;
  localparam tkd_key_t K_DOWN  = 9'd259;
  localparam tkd_key_t K_DEL   = 9'd260;
  localparam tkd_key_t K_HOME  = 9'd261;
  localparam tkd_key_t K_END   = 9'd262;
  localparam tkd_key_t K_PGUP  = 9'd263;
  localparam tkd_key_t K_PGDN  = 9'd264;

  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_LBRK  = 8'h5b;  // '['
  localparam logic [7:0] CH_TILDE = 8'h7e;  // '~'
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_O     = 8'h4f;

endpackage

`default_nettype wire

// ----- design/tkd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "terminal_key_decoder_cursor_assert.svh"

module tkd_front
  import tkd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire tkd_in_t    in_data,
  input  wire tkd_qstat_t qstat,
  output tkd_push_t       push_o
);

  tkd_phase_t phase_r, phase_nxt;
  logic [7:0] first_r, first_nxt;
  logic [7:0] second_r, second_nxt;
  logic       accept;
  logic [7:0] b;

  function automatic tkd_key_t decode_bracket(input logic [7:0] c);
    tkd_key_t k;
    case (c)
      CH_A:    k = K_UP;
      CH_B:    k = K_DOWN;
      CH_C:    k = K_RIGHT;
      CH_D:    k = K_LEFT;
      CH_H:    k = K_HOME;
      CH_F:    k = K_END;
      default: k = K_ESC;
    endcase
    return k;
  endfunction

  function automatic tkd_key_t decode_tilde(input logic [7:0] d);
    tkd_key_t k;
    case (d)
      CH_1, CH_7: k = K_HOME;
      CH_4, CH_8: k = K_END;
      CH_3:       k = K_DEL;
      CH_5:       k = K_PGUP;
      CH_6:       k = K_PGDN;
      default:    k = K_ESC;
    endcase
    return k;
  endfunction

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.data_byte;

  always_comb begin
    phase_nxt   = phase_r;
    first_nxt   = first_r;
    second_nxt  = second_r;
    push_o.push = 1'b0;
    push_o.key  = K_ESC;
    if (accept) begin
      if (in_data.timed_out) begin
        if (phase_r != PH_IDLE) begin
          push_o.push = 1'b1;
          phase_nxt   = PH_IDLE;
        end
      end else begin
        case (phase_r)
          PH_ESC: begin
            first_nxt = b;
            phase_nxt = PH_SEQ1;
          end
          PH_SEQ1: begin
            phase_nxt = PH_IDLE;
            if (first_r == CH_LBRK) begin
              if (b inside {[CH_0:CH_9]}) begin
                second_nxt = b;
                phase_nxt  = PH_DIGIT;
              end else begin
                push_o.push = 1'b1;
                push_o.key  = decode_bracket(b);
              end
            end else if (first_r == CH_O) begin
              push_o.push = 1'b1;
              push_o.key  = (b == CH_H) ? K_HOME : ((b == CH_E) ? K_END : K_ESC);
            end else begin
              push_o.push = 1'b1;
            end
          end
          PH_DIGIT: begin
            phase_nxt   = PH_IDLE;
            push_o.push = 1'b1;
            push_o.key  = (b == CH_TILDE) ? decode_tilde(second_r) : K_ESC;
          end
          default: begin
            if (b == CH_ESC) begin
              phase_nxt = PH_ESC;
            end else begin
              push_o.push = 1'b1;
              push_o.key  = {1'b0, b};
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      first_r  <= '0;
      second_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

  `TKD_ASSERT_IMPL(a_idle_tmo_silent, clk, rst_n, accept && in_data.timed_out && phase_r == PH_IDLE, !push_o.push, "timeout while idle produced a key")
  `TKD_ASSERT_NEXT(a_esc_enters_seq, clk, rst_n, accept && !in_data.timed_out && phase_r == PH_IDLE && in_data.data_byte == CH_ESC, phase_r == PH_ESC, "ESC did not start a sequence")

endmodule

`default_nettype wire

// ----- design/tkd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "terminal_key_decoder_cursor_assert.svh"

module tkd_queue
  import tkd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire tkd_push_t push_i,
  input  wire logic      pop,
  output tkd_qstat_t     stat,
  output tkd_key_t       head
);

  tkd_key_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign stat.full  = cnt_r == 2'd2;
  assign stat.empty = cnt_r == 2'd0;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_i.push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push_i.push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push_i.push) begin
      mem_r[wr_ptr_r] <= push_i.key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `TKD_ASSERT_IMPL(a_no_overflow, clk, rst_n, push_i.push, !stat.full, "key pushed into full queue")
  `TKD_ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, !stat.empty, "key popped from empty queue")

endmodule

`default_nettype wire

// ----- design/tkd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "terminal_key_decoder_cursor_assert.svh"

module tkd_back
  import tkd_pkg::*;
#(
  parameter int COORD_BITS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [8:0] cfg_wdata,
  input  wire tkd_qstat_t qstat,
  input  wire tkd_key_t   head,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output tkd_out_t        out_data
);

  localparam int LW = (COORD_BITS > 9) ? COORD_BITS : 9;
  localparam int XW = (COORD_BITS > 8) ? COORD_BITS : 8;
  localparam logic [LW-1:0] CMAX = LW'({COORD_BITS{1'b1}});

  logic [8:0] rows_r, cols_r;
  logic [COORD_BITS-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [COORD_BITS-1:0] lx, ly;
  logic [8:0] lim_x, lim_y;
  logic [LW-1:0] lim_x_w, lim_y_w;
  logic [XW-1:0] cx_w, cy_w;
  logic out_valid_r;
  tkd_out_t out_r;

  // last column/row: size 0 acts as 1, capped at the coordinate range
  always_comb begin
    lim_x   = (cols_r == 9'd0) ? 9'd0 : cols_r - 9'd1;
    lim_y   = (rows_r == 9'd0) ? 9'd0 : rows_r - 9'd1;
    lim_x_w = LW'(lim_x);
    lim_y_w = LW'(lim_y);
    lx = (lim_x_w > CMAX) ? CMAX[COORD_BITS-1:0] : lim_x_w[COORD_BITS-1:0];
    ly = (lim_y_w > CMAX) ? CMAX[COORD_BITS-1:0] : lim_y_w[COORD_BITS-1:0];
  end

  assign pop = !qstat.empty && (!out_valid_r || out_ready);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    case (head)
      K_LEFT:  col_nxt = (col_r != '0) ? col_r - 1'b1 : col_r;
      K_RIGHT: col_nxt = (col_r >= lx) ? lx : col_r + 1'b1;
      K_UP:    row_nxt = (row_r != '0) ? row_r - 1'b1 : row_r;
      K_DOWN:  row_nxt = (row_r >= ly) ? ly : row_r + 1'b1;
      K_HOME:  col_nxt = '0;
      K_END:   col_nxt = lx;
      K_PGUP:  row_nxt = '0;
      K_PGDN:  row_nxt = ly;
      default: ;
    endcase
    cx_w = XW'(col_nxt);
    cy_w = XW'(row_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_RST;
      cols_r <= COLS_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_ROWS) begin
        rows_r <= cfg_wdata;
      end else begin
        cols_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        col_r       <= col_nxt;
        row_r       <= row_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r.key_code <= head;
      out_r.cursor_x <= cx_w[7:0];
      out_r.cursor_y <= cy_w[7:0];
      out_r.quit     <= head == K_CTRLX;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `TKD_ASSERT_NEXT(a_pop_shows, clk, rst_n, pop, out_valid_r && out_r.key_code == $past(head), "popped key not presented")

endmodule

`default_nettype wire

// ----- design/terminal_key_decoder_cursor.sv -----
// An accepted item goes through the key queue, then the output register, to out_*.
// Throughput: one item per cycle while in_ready is high; the two-entry key queue
// and the output register let the parser and the cursor stage stall independently.
// Items that end inside an escape sequence (or a timeout while idle) give no result.
// Reset (rst_n low, synchronous): parser idle, cursor at 0,0, queue and output empty,
// screen_rows = 24, screen_cols = 80.
`timescale 1ns / 1ps
`default_nettype none

module terminal_key_decoder_cursor
  import tkd_pkg::*;
#(
  parameter int COORD_BITS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire tkd_in_t    in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output tkd_out_t        out_data,
  input  wire logic       cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [8:0] cfg_wdata
);

  tkd_push_t  push;
  tkd_qstat_t qstat;
  tkd_key_t   head;
  logic       pop;

  tkd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .qstat    (qstat),
    .push_o   (push)
  );

  tkd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .pop    (pop),
    .stat   (qstat),
    .head   (head)
  );

  tkd_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .qstat     (qstat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- verif/terminal_key_decoder_cursor_tb.sv -----
`timescale 1ns / 1ps

module terminal_key_decoder_cursor_tb;
  import tkd_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  tkd_in_t    in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  tkd_out_t   out_data;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_index = REG_ROWS;
  logic [8:0] cfg_wdata = '0;

  terminal_key_decoder_cursor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Shadow of the decoder and cursor
  tkd_phase_t parse_ph = PH_IDLE;
  logic [7:0] seq_lead = '0;
  logic [7:0] seq_digit = '0;
  logic [7:0] col_pos = '0;
  logic [7:0] row_pos = '0;
  logic [8:0] scr_rows = ROWS_RST;
  logic [8:0] scr_cols = COLS_RST;

  tkd_in_t     tx_bytes[$];
  tkd_out_t    pending_keys[$];
  int unsigned queued_total = 0;
  int unsigned errors = 0;

  logic        in_took = 1'b0;
  logic        calm = 1'b0;
  logic        want_hold = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  int unsigned hold_left = 0;

  function automatic logic [7:0] last_pos(logic [8:0] size);
    logic [8:0] lim;
    lim = (size == 9'd0) ? 9'd0 : size - 9'd1;
    return (lim > 9'd255) ? 8'hff : lim[7:0];
  endfunction

  function automatic logic [7:0] step_toward(logic [7:0] pos, logic [7:0] lim);
    return (pos >= lim) ? lim : pos + 8'd1;
  endfunction

  function automatic void predict_key(tkd_in_t it);
    tkd_key_t   key;
    logic       hit;
    logic [7:0] lx;
    logic [7:0] ly;
    tkd_out_t   r;
    hit = 1'b0;
    key = K_ESC;
    lx = last_pos(scr_cols);
    ly = last_pos(scr_rows);
    if (it.timed_out) begin
      if (parse_ph != PH_IDLE) begin
        hit = 1'b1;
        parse_ph = PH_IDLE;
      end
    end else begin
      case (parse_ph)
        PH_ESC: begin
          seq_lead = it.data_byte;
          parse_ph = PH_SEQ1;
        end
        PH_SEQ1: begin
          parse_ph = PH_IDLE;
          if (seq_lead == CH_LBRK && it.data_byte >= CH_0 && it.data_byte <= CH_9) begin
            seq_digit = it.data_byte;
            parse_ph = PH_DIGIT;
          end else begin
            hit = 1'b1;
            if (seq_lead == CH_LBRK) begin
              case (it.data_byte)
                CH_A:    key = K_UP;
                CH_B:    key = K_DOWN;
                CH_C:    key = K_RIGHT;
                CH_D:    key = K_LEFT;
                CH_H:    key = K_HOME;
                CH_F:    key = K_END;
                default: key = K_ESC;
              endcase
            end else if (seq_lead == CH_O) begin
              if (it.data_byte == CH_H) key = K_HOME;
              else if (it.data_byte == CH_E) key = K_END;
            end
          end
        end
        PH_DIGIT: begin
          parse_ph = PH_IDLE;
          hit = 1'b1;
          if (it.data_byte == CH_TILDE) begin
            case (seq_digit)
              CH_1, CH_7: key = K_HOME;
              CH_4, CH_8: key = K_END;
              CH_3:       key = K_DEL;
              CH_5:       key = K_PGUP;
              CH_6:       key = K_PGDN;
              default:    key = K_ESC;
            endcase
          end
        end
        default: begin
          if (it.data_byte == CH_ESC) begin
            parse_ph = PH_ESC;
          end else begin
            hit = 1'b1;
            key = {1'b0, it.data_byte};
          end
        end
      endcase
    end
    if (hit) begin
      case (key)
        K_LEFT:  if (col_pos != 8'd0) col_pos = col_pos - 8'd1;
        K_RIGHT: col_pos = step_toward(col_pos, lx);
        K_UP:    if (row_pos != 8'd0) row_pos = row_pos - 8'd1;
        K_DOWN:  row_pos = step_toward(row_pos, ly);
        K_HOME:  col_pos = 8'd0;
        K_END:   col_pos = lx;
        K_PGUP:  row_pos = 8'd0;
        K_PGDN:  row_pos = ly;
        default: ;
      endcase
      r.key_code = key;
      r.cursor_x = col_pos;
      r.cursor_y = row_pos;
      r.quit     = (key == K_CTRLX);
      pending_keys.push_back(r);
    end
  endfunction

  // Monitor: input acceptance feeds the shadow, output acceptance is checked
  always @(posedge clk) begin
    tkd_out_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) predict_key(in_data);
      if (out_valid && out_ready) begin
        if (pending_keys.size() == 0) begin
          $error("unexpected key out: key_code %0d", out_data.key_code);
          errors++;
        end else begin
          want = pending_keys.pop_front();
          if (out_data.key_code !== want.key_code) begin
            $error("key_code: expected %0d, actual %0d", want.key_code, out_data.key_code);
            errors++;
          end
          if (out_data.cursor_x !== want.cursor_x) begin
            $error("cursor_x: expected %0d, actual %0d", want.cursor_x, out_data.cursor_x);
            errors++;
          end
          if (out_data.cursor_y !== want.cursor_y) begin
            $error("cursor_y: expected %0d, actual %0d", want.cursor_y, out_data.cursor_y);
            errors++;
          end
          if (out_data.quit !== want.quit) begin
            $error("quit: expected %0d, actual %0d", want.quit, out_data.quit);
            errors++;
          end
        end
      end
    end
  end

  // Sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (tx_gap > 0) begin
        in_valid <= 1'b0;
        tx_gap--;
      end else if (tx_bytes.size() > 0) begin
        in_data  <= tx_bytes.pop_front();
        in_valid <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 10);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver; one long hold-off lets the key queue fill and back up the input
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (want_hold && !hold_done) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (rx_gap > 0) begin
        out_ready <= 1'b0;
        rx_gap--;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) rx_gap = $urandom_range(1, 10);
      end
    end
  end

  function automatic void put_byte(logic [7:0] b);
    tkd_in_t t;
    t.data_byte = b;
    t.timed_out = 1'b0;
    tx_bytes.push_back(t);
    queued_total++;
  endfunction

  function automatic void put_timeout();
    tkd_in_t t;
    t.data_byte = 8'($urandom_range(0, 255));
    t.timed_out = 1'b1;
    tx_bytes.push_back(t);
    queued_total++;
  endfunction

  function automatic logic [7:0] any_digit();
    return 8'($urandom_range(CH_0, CH_9));
  endfunction

  function automatic void add_sequence();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      put_byte(CH_ESC);
      put_byte(CH_LBRK);
      case ($urandom_range(0, 9))
        0, 1:    put_byte(CH_A);
        2, 3:    put_byte(CH_B);
        4, 5:    put_byte(CH_C);
        6, 7:    put_byte(CH_D);
        8:       put_byte(CH_H);
        default: put_byte(CH_F);
      endcase
    end else if (pick < 42) begin
      put_byte(CH_ESC);
      put_byte(CH_LBRK);
      put_byte(any_digit());
      put_byte(CH_TILDE);
    end else if (pick < 47) begin
      put_byte(CH_ESC);
      put_byte(CH_O);
      put_byte($urandom_range(0, 1) ? CH_H : CH_E);
    end else if (pick < 75) begin
      put_byte(($urandom_range(0, 9) == 0) ? K_CTRLX[7:0] : 8'($urandom_range(0, 255)));
    end else if (pick < 80) begin
      put_timeout();
    end else begin
      // broken or cut-off sequences
      put_byte(CH_ESC);
      case ($urandom_range(0, 4))
        0: begin
          put_byte(8'($urandom_range(0, 255)));
          put_byte(8'($urandom_range(0, 255)));
        end
        1: put_timeout();
        2: begin
          put_byte(CH_LBRK);
          put_timeout();
        end
        3: begin
          put_byte(CH_LBRK);
          put_byte(any_digit());
          if ($urandom_range(0, 3) == 0) put_timeout();
          else put_byte(8'($urandom_range(0, 255)));
        end
        default: begin
          put_byte(CH_O);
          put_byte(8'($urandom_range(0, 255)));
        end
      endcase
    end
  endfunction

  task automatic set_screen(logic [8:0] rows, logic [8:0] cols);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROWS;
    cfg_wdata <= rows;
    scr_rows = rows;
    @(negedge clk);
    cfg_index <= REG_COLS;
    cfg_wdata <= cols;
    scr_cols = cols;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // An item can leave no result, so the task waits on past the last key out.
  // The check runs just after the falling edge so the sender's update is seen.
  task automatic wait_drained();
    do begin
      @(negedge clk);
      #1;
    end while (tx_bytes.size() != 0 || in_valid || pending_keys.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  initial begin
    int unsigned stop;
    logic [8:0]  rows;
    logic [8:0]  cols;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset screen size
    put_byte(8'h00);
    put_byte(8'hff);
    put_byte(K_CTRLX[7:0]);
    put_timeout();
    put_byte(CH_ESC); put_byte(CH_LBRK); put_byte(CH_D);
    put_byte(CH_ESC); put_byte(CH_LBRK); put_byte(CH_A);
    put_byte(CH_ESC); put_byte(CH_LBRK); put_byte(CH_6); put_byte(CH_TILDE);
    put_byte(CH_ESC); put_byte(CH_O); put_byte(CH_E);
    put_byte(CH_ESC); put_timeout();
    put_byte(CH_ESC); put_byte(CH_LBRK); put_timeout();
    put_byte(CH_ESC); put_byte(8'h78); put_byte(8'h79);
    put_byte(CH_ESC); put_byte(CH_LBRK); put_byte(CH_9); put_byte(CH_TILDE);
    wait_drained();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin rows = 9'd1;   cols = 9'd1;   end
        1: begin rows = 9'd256; cols = 9'd256; end
        2: begin rows = 9'd5;   cols = 9'd3;   end  // shrink below the cursor
        3: begin rows = 9'd0;   cols = 9'd0;   end
        4: begin rows = 9'd511; cols = 9'd300; end
        default: begin
          if ($urandom_range(0, 1)) begin
            rows = 9'($urandom_range(1, 12));
            cols = 9'($urandom_range(1, 12));
          end else begin
            rows = 9'($urandom_range(0, 511));
            cols = 9'($urandom_range(0, 511));
          end
        end
      endcase
      calm = (ph >= 7);
      set_screen(rows, cols);
      stop = queued_total + 220;
      while (queued_total < stop) add_sequence();
      if (ph == 2) want_hold = 1'b1;
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (errors == 0 && pending_keys.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
